// ===== design/rgbhsb_pkg.sv =====
// Shared widths and pipeline record for the RGB to HSB converter.
// No dependencies.
`default_nettype none
package rgbhsb_pkg;
  localparam int unsigned QuoW  = 17;
  // Wide enough for 2*HSB_MAX times a hue numerator of up to 6*delta.
  localparam int unsigned RemW  = 36;

  // One lane of the divider array: a quotient being built bit by bit.
  typedef struct packed {
    logic [RemW-1:0] rem;
    logic [RemW-1:0] den;
    logic [QuoW-1:0] quo;
  } div_lane_t;

  typedef struct packed {
    logic       vld;
    logic       zero;
    logic       bri_full;
    div_lane_t  bri;
    div_lane_t  sat;
    div_lane_t  hue;
  } stage_t;
endpackage
`default_nettype wire

// ===== design/rgb_to_hsb_convert.sv =====
// Top level of the RGB to HSB converter: front end, divider cell chain, output.
// Depends on rgbhsb_pkg and rgbhsb_cell.
//
// Usage: pixels enter on in_* as one word of red, green and blue and leave
// on out_* as one word of hue, saturation and brightness. No state links
// pixels; every input word yields exactly one output word.
// The front end finds max, min and sector, then forms the rounded-division
// numerators for brightness, saturation and hue. All three quotients then
// pass a chain of 17 identical cells, one quotient bit per cell, and the
// last cell's register drives the output. From acceptance to out_tvalid a
// word passes the front register and the 17 cells; throughput is one word
// per cycle while the receiver keeps out_tready high.
// Brightness saturates at HSB_MAX whenever the largest component reaches
// RGB_MAX, so its quotient always fits the cell chain.
// The whole pipeline advances together: when the receiver holds
// out_tready low with a word waiting, the chain freezes and in_tready
// drops, so no word is lost. Bubbles are filled whenever the output
// register is empty. Reset clears all valid flags; payload is not reset.
`default_nettype none
module rgb_to_hsb_convert
  import rgbhsb_pkg::*;
#(
  parameter int unsigned RGB_MAX = 65535,
  parameter int unsigned HSB_MAX = 65535
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // red_in, green_in, blue_in
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0] out_tdata        // hue_out, saturation_out, brightness_out
);
  localparam int unsigned NCells = QuoW;

  logic en;
  assign en = out_tready || !out_tvalid;
  assign in_tready = en;

  logic [15:0] r, g, b, mx, mn, dl;
  logic [18:0] num;
  logic signed [19:0] snum;
  stage_t front_nxt, front_r;

  assign r = in_tdata[15:0];
  assign g = in_tdata[31:16];
  assign b = in_tdata[47:32];

  always_comb begin
    mx = r; mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    dl = mx - mn;
    if (r == mx) begin
      snum = $signed({4'd0, g}) - $signed({4'd0, b});
    end else if (g == mx) begin
      snum = $signed({3'd0, dl, 1'b0}) + $signed({4'd0, b}) - $signed({4'd0, r});
    end else begin
      snum = $signed({2'd0, dl, 2'd0}) + $signed({4'd0, r}) - $signed({4'd0, g});
    end
    if (snum < 0) snum = snum + $signed({2'd0, dl, 2'd0}) + $signed({3'd0, dl, 1'b0});
    num = snum[18:0];
    front_nxt.vld  = in_tvalid;
    front_nxt.zero = (mx == 16'd0) || (dl == 16'd0);
    // Brightness: rounded HSB_MAX*mx/RGB_MAX, saturating once mx reaches RGB_MAX.
    front_nxt.bri_full = (mx >= 16'(RGB_MAX));
    front_nxt.bri.rem = 36'(2 * HSB_MAX) * {20'd0, mx} + 36'(RGB_MAX);
    front_nxt.bri.den = 36'(2 * RGB_MAX);
    front_nxt.bri.quo = '0;
    // round(a/d) = floor((2a+d)/(2d))
    front_nxt.sat.rem = 36'(2 * HSB_MAX) * {20'd0, dl} + {20'd0, mx};
    front_nxt.sat.den = {19'd0, mx, 1'b0};
    front_nxt.sat.quo = '0;
    front_nxt.hue.rem = 36'(2 * HSB_MAX) * {17'd0, num} + 36'({dl, 2'd0}) + 36'({dl, 1'b0});
    front_nxt.hue.den = 36'({dl, 3'd0}) + 36'({dl, 2'd0});
    front_nxt.hue.quo = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r.vld <= 1'b0;
    end else if (en) begin
      front_r <= front_nxt;
    end
  end

  stage_t chain [NCells+1];
  assign chain[0] = front_r;

  for (genvar i = 0; i < NCells; i++) begin : g_cell
    rgbhsb_cell #(.BitIdx(NCells-1-i)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en), .s_in(chain[i]), .s_out(chain[i+1])
    );
  end

  stage_t last;
  logic [15:0] bri_val;
  assign last = chain[NCells];
  assign bri_val = last.bri_full ? 16'(HSB_MAX) : last.bri.quo[15:0];
  assign out_tvalid = last.vld;
  assign out_tdata = last.zero ? {bri_val, 32'd0}
                               : {bri_val, last.sat.quo[15:0], last.hue.quo[15:0]};
endmodule
`default_nettype wire

// ===== design/rgbhsb_cell.sv =====
// One restoring division step for the brightness, saturation and hue lanes.
// Depends on rgbhsb_pkg.
`default_nettype none
module rgbhsb_cell
  import rgbhsb_pkg::*;
#(
  parameter int unsigned BitIdx = 0
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   en,
  input  wire stage_t s_in,
  output stage_t      s_out
);
  stage_t s_r, s_nxt;

  function automatic div_lane_t step(input div_lane_t l);
    div_lane_t o;
    logic [2*RemW-1:0] trial;
    o = l;
    trial = {{RemW{1'b0}}, l.den} << BitIdx;
    if ({{RemW{1'b0}}, l.rem} >= trial) begin
      o.rem = l.rem - trial[RemW-1:0];
      o.quo[BitIdx] = 1'b1;
    end
    return o;
  endfunction

  always_comb begin
    s_nxt = s_in;
    s_nxt.bri = step(s_in.bri);
    s_nxt.sat = step(s_in.sat);
    s_nxt.hue = step(s_in.hue);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r.vld <= 1'b0;
    end else if (en) begin
      s_r <= s_nxt;
    end
  end
  assign s_out = s_r;
endmodule
`default_nettype wire

// ===== test/tb_rgb_to_hsb_convert.sv =====
// Testbench for rgb_to_hsb_convert: drives pixel words with random gaps and
// output stalls, predicts hue, saturation and brightness and checks each word.
// Depends on rgbhsb_pkg and the rgb_to_hsb_convert RTL.
`timescale 1ns / 100ps
`default_nettype none

class hsb_scoreboard;
  logic [47:0] pending_hsb[$];
  int unsigned errors;
  int unsigned words_checked;

  // Rounded-half-up quotient, computed exactly on 64-bit values.
  function longint unsigned round_div(longint unsigned n, longint unsigned d);
    return (2 * n + d) / (2 * d);
  endfunction

  // Predicts hue, saturation and brightness for one accepted pixel.
  function void note_pixel(logic [47:0] rgb);
    longint r, g, b, mx, mn, delta, num;
    longint unsigned hue, sat, bri;
    r = rgb[15:0];
    g = rgb[31:16];
    b = rgb[47:32];
    mx = r;
    mn = r;
    hue = 0;
    sat = 0;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    bri = round_div(65535 * mx, 65535);
    if (bri > 65535) bri = 65535;
    if (mx != 0 && mx != mn) begin
      delta = mx - mn;
      sat = round_div(65535 * delta, mx);
      // Red wins ties, then green, then blue.
      if (r == mx) num = g - b;
      else if (g == mx) num = 2 * delta + (b - r);
      else num = 4 * delta + (r - g);
      if (num < 0) num += 6 * delta;
      hue = round_div(65535 * num, 6 * delta);
    end
    pending_hsb.push_back({bri[15:0], sat[15:0], hue[15:0]});
  endfunction

  // Compares one output word with the oldest prediction.
  function void check_word(logic [47:0] hsb);
    logic [47:0] exp_hsb;
    words_checked++;
    if (pending_hsb.size() == 0) begin
      errors++;
      if (errors <= 10) $display("ERROR: unexpected output word %h", hsb);
      return;
    end
    exp_hsb = pending_hsb.pop_front();
    if (hsb !== exp_hsb) begin
      errors++;
      if (errors <= 10)
        $display("ERROR: hue %h/%h sat %h/%h bri %h/%h (expected/actual)",
                 exp_hsb[15:0], hsb[15:0], exp_hsb[31:16], hsb[31:16],
                 exp_hsb[47:32], hsb[47:32]);
    end
  endfunction
endclass

module tb_rgb_to_hsb_convert;
  import rgbhsb_pkg::*;

  localparam int unsigned LATENCY = 18;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RANDOM_PIXELS = 400;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;   // red_in, green_in, blue_in
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;  // hue_out, saturation_out, brightness_out

  hsb_scoreboard hsb_sb;
  int unsigned cycle_count;
  int unsigned pixels_sent;
  // When set, both sides run without random gaps.
  logic        no_idle;
  // When set, the receiver holds off for a long stretch.
  logic        hold_off;

  rgb_to_hsb_convert u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    hsb_sb = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    no_idle = 1'b0;
    hold_off = 1'b0;
    cycle_count = 0;
    pixels_sent = 0;
  end

  // Watchdog and the monitor: a word counts when out_tvalid and out_tready
  // are both high at the rising edge, sampled before the edge updates.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n && out_tvalid && out_tready) hsb_sb.check_word(out_tdata);
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("rgb_to_hsb_convert: mismatch");
      $finish;
    end
  end

  // Receiver: random stalls, none in the quiet stretch, all during hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_off) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= no_idle || ($urandom_range(99) >= 36);
    end
  end

  // Receiver hold-off, counted in cycles here while the sender keeps offering
  // words, so the pipeline fills and in_tready drops.
  initial begin
    wait (pixels_sent >= 150);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (200) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Offers one pixel word and waits until the block takes it. Random gaps
  // come before the word; with no gap, valid stays high from one word to the next.
  task automatic send_pixel(logic [15:0] r, logic [15:0] g, logic [15:0] b);
    while (!no_idle && $urandom_range(99) < 36) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {b, g, r};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    hsb_sb.note_pixel({b, g, r});
    pixels_sent++;
  endtask

  // Random component: often an extreme, otherwise any value.
  function automatic logic [15:0] rand_comp();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(3));
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [15:0] r, g, b;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: black, white, grey, primaries, secondaries, ties for the
    // maximum, hue just below a full turn and tiny deltas.
    send_pixel(16'h0000, 16'h0000, 16'h0000);
    send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_pixel(16'h8000, 16'h8000, 16'h8000);
    send_pixel(16'hFFFF, 16'h0000, 16'h0000);
    send_pixel(16'h0000, 16'hFFFF, 16'h0000);
    send_pixel(16'h0000, 16'h0000, 16'hFFFF);
    send_pixel(16'hFFFF, 16'hFFFF, 16'h0000);
    send_pixel(16'h0000, 16'hFFFF, 16'hFFFF);
    send_pixel(16'hFFFF, 16'h0000, 16'hFFFF);
    send_pixel(16'hFFFF, 16'h0000, 16'h0001);
    send_pixel(16'hFFFF, 16'hFFFE, 16'hFFFF);
    send_pixel(16'h0001, 16'h0000, 16'h0000);
    send_pixel(16'h0000, 16'h0001, 16'h0001);
    send_pixel(16'h0001, 16'h0000, 16'h0001);
    send_pixel(16'h1234, 16'hABCD, 16'h5678);
    send_pixel(16'h5555, 16'hAAAA, 16'hFFFF);
    send_pixel(16'hFFFF, 16'h0001, 16'h0000);
    send_pixel(16'h0002, 16'h0001, 16'h0000);

    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      // A long stretch without gaps on either side.
      no_idle = (i >= 250 && i < 320);
      r = rand_comp();
      g = rand_comp();
      b = rand_comp();
      // Some ties between two components.
      if ($urandom_range(9) == 0) g = r;
      if ($urandom_range(9) == 0) b = ($urandom_range(1) != 0) ? r : g;
      send_pixel(r, g, b);
    end
    in_tvalid <= 1'b0;
    no_idle = 1'b0;

    while (hsb_sb.pending_hsb.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);

    $display("Sent %0d pixels (extremes, greys, ties, all sectors), checked %0d words.",
             pixels_sent, hsb_sb.words_checked);
    if (hsb_sb.errors == 0) begin
      $display("rgb_to_hsb_convert: match");
    end else begin
      $display("%0d mismatches", hsb_sb.errors);
      $display("rgb_to_hsb_convert: mismatch");
    end
    $finish;
  end
endmodule

`default_nettype wire
